// ----- rtl/bsu_pkg.sv -----
`timescale 1ns / 1ps
package bsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_run_last;
   } rsp_type;

   // Text format codes, held while a buffer is being processed.
   typedef enum logic [2:0] {
      FMT_CHECK = 3'd0,
      FMT_U32BE = 3'd1,
      FMT_U32LE = 3'd2,
      FMT_U16BE = 3'd3,
      FMT_U16LE = 3'd4,
      FMT_PASS  = 3'd5
   } fmt_type;

   // Up to six output bytes caused by one input word, first byte at index 0.
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      count;
   } grp_type;

   localparam int unsigned MAX_BYTES = 6;

   localparam logic [7:0] BOM_FF = 8'hFF;
   localparam logic [7:0] BOM_FE = 8'hFE;
   localparam logic [7:0] BOM_00 = 8'h00;
   localparam logic [7:0] BOM_EF = 8'hEF;
   localparam logic [7:0] BOM_BB = 8'hBB;
   localparam logic [7:0] BOM_BF = 8'hBF;

   localparam logic [12:0] LEAD_BASE = 13'h1F80;
   localparam logic [5:0]  CONT_MASK = 6'h3F;
   localparam logic [1:0]  CONT_TAG  = 2'b10;

   localparam logic [31:0] LIM_SIX   = 32'h0400_0000;
   localparam logic [31:0] LIM_FIVE  = 32'h0020_0000;
   localparam logic [31:0] LIM_FOUR  = 32'h0001_0000;
   localparam logic [31:0] LIM_THREE = 32'h0000_0800;
   localparam logic [31:0] LIM_TWO   = 32'h0000_0080;

endpackage

// ----- rtl/bom_sniff_utf_to_utf8.sv -----
`timescale 1ns / 1ps
// Transcodes one buffer of BOM-marked text to UTF-8, one input byte per word. The first
// four bytes (or fewer, up to the one flagged last) are held for the BOM check; the BOM is
// dropped and, with no BOM, the held bytes are released together. UTF-32 and UTF-16 units
// are emitted as UTF-8 of one to six bytes, while UTF-8 and unmarked text pass through
// without the UTF-8 BOM. After the last byte the block starts a new BOM check. An accepted
// byte is worked on while it sits in the input register, and its output bytes leave one per
// cycle from a shift register unless the output stalls. A byte causes up to four output
// bytes at the BOM decision and up to six for a UTF-32 unit.
module bom_sniff_utf_to_utf8
   import bsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    grp_valid;
   logic    grp_ready;
   grp_type grp_data;

   bsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .grp_data  (grp_data)
   );

   bsu_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .grp_data  (grp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/bsu_enc.sv -----
`timescale 1ns / 1ps
module bsu_enc
   import bsu_pkg::*;
(
   input  logic [31:0] unit,
   output grp_type     grp
);

   logic [2:0]       k;
   logic [7:0]       lead_hi;
   logic [7:0]       lead_lo;
   logic [5:0][5:0]  chunk;
   logic [2:0]       s;

   always_comb begin
      s = 3'd0;
      // Six-bit slices of the unit; the top slice has only two bits.
      for (int i = 0; i < 5; i++) begin
         chunk[i] = unit[6*i +: 6] & CONT_MASK;
      end
      chunk[5] = {4'b0000, unit[31:30]};

      if (unit >= LIM_SIX) begin
         k = 3'd5;
      end else if (unit >= LIM_FIVE) begin
         k = 3'd4;
      end else if (unit >= LIM_FOUR) begin
         k = 3'd3;
      end else if (unit >= LIM_THREE) begin
         k = 3'd2;
      end else begin
         k = 3'd1;
      end

      lead_hi = 8'((LEAD_BASE >> k) & 13'h00FF);
      unique case (k)
         3'd1:    lead_lo = unit[13:6];
         3'd2:    lead_lo = unit[19:12];
         3'd3:    lead_lo = unit[25:18];
         3'd4:    lead_lo = unit[31:24];
         default: lead_lo = {6'b000000, unit[31:30]};
      endcase

      grp.bytes = '0;
      if (unit < LIM_TWO) begin
         grp.bytes[0] = unit[7:0];
         grp.count    = 3'd1;
      end else begin
         grp.bytes[0] = lead_hi | lead_lo;
         for (int j = 1; j < 6; j++) begin
            s = 3'(k - 3'(j));
            if (3'(j) <= k) begin
               grp.bytes[j] = {CONT_TAG, chunk[s]};
            end
         end
         grp.count = 3'(k + 3'd1);
      end
   end

endmodule

// ----- rtl/bsu_front.sv -----
`timescale 1ns / 1ps
module bsu_front
   import bsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    grp_valid,
   input  logic    grp_ready,
   output grp_type grp_data
);

   req_type         item_ff;
   logic            full_ff,  full_in;
   fmt_type         fmt_ff,   fmt_in;
   logic [2:0][7:0] held_ff,  held_in;
   logic [1:0]      cnt_ff,   cnt_in;
   logic [31:0]     uval_ff,  uval_in;
   logic [1:0]      ubc_ff,   ubc_in;
   logic            stop_ff,  stop_in;

   logic            accept;
   logic            adv;
   logic [7:0]      b;
   logic [3:0][7:0] h;
   logic            n4, n3, n2;
   logic            use_enc;
   logic [31:0]     enc_unit;
   logic [31:0]     base;
   logic [31:0]     v;
   logic            unit_done;
   grp_type         enc_grp;
   grp_type         grp;

   bsu_enc u_enc (
      .unit (enc_unit),
      .grp  (enc_grp)
   );

   assign b = item_ff.in_byte;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h[i] = (2'(i) == cnt_ff) ? b : held_ff[i];
      end
      h[3] = b;
   end

   assign n4 = (cnt_ff == 2'd3);
   assign n3 = (cnt_ff >= 2'd2);
   assign n2 = (cnt_ff >= 2'd1);

   always_comb begin
      fmt_in    = fmt_ff;
      held_in   = held_ff;
      cnt_in    = cnt_ff;
      uval_in   = uval_ff;
      ubc_in    = ubc_ff;
      stop_in   = stop_ff;
      grp       = '0;
      use_enc   = 1'b0;
      enc_unit  = '0;
      base      = '0;
      v         = '0;
      unit_done = 1'b0;

      unique case (fmt_ff)
         FMT_PASS: begin
            grp.bytes[0] = b;
            grp.count    = 3'd1;
         end
         FMT_U32BE, FMT_U32LE, FMT_U16BE, FMT_U16LE: begin
            if (!stop_ff) begin
               base = (ubc_ff == 2'd0) ? 32'd0 : uval_ff;
               if (fmt_ff == FMT_U32BE || fmt_ff == FMT_U16BE) begin
                  v = {base[23:0], b};
               end else begin
                  case (ubc_ff)
                     2'd0:    v = base | {24'd0, b};
                     2'd1:    v = base | {16'd0, b, 8'd0};
                     2'd2:    v = base | {8'd0, b, 16'd0};
                     default: v = base | {b, 24'd0};
                  endcase
               end
               uval_in = v;
               if (fmt_ff == FMT_U32BE || fmt_ff == FMT_U32LE) begin
                  unit_done = (ubc_ff == 2'd3);
               end else begin
                  unit_done = (ubc_ff == 2'd1);
               end
               if (unit_done) begin
                  ubc_in = 2'd0;
                  if (v == 32'd0) begin
                     stop_in = 1'b1;
                  end else begin
                     use_enc  = 1'b1;
                     enc_unit = v;
                  end
               end else begin
                  ubc_in = 2'(ubc_ff + 2'd1);
               end
            end
         end
         default: begin
            // Still gathering the leading bytes for the BOM check.
            fmt_in = FMT_CHECK;
            for (int i = 0; i < 3; i++) begin
               if (2'(i) == cnt_ff) begin
                  held_in[i] = b;
               end
            end
            cnt_in = 2'(cnt_ff + 2'd1);
            if (n4 || item_ff.in_last) begin
               cnt_in  = 2'd0;
               ubc_in  = 2'd0;
               stop_in = 1'b0;
               if (n4 && h[0] == BOM_00 && h[1] == BOM_00
                      && h[2] == BOM_FE && h[3] == BOM_FF) begin
                  fmt_in = FMT_U32BE;
               end else if (n4 && h[0] == BOM_FF && h[1] == BOM_FE
                      && h[2] == BOM_00 && h[3] == BOM_00) begin
                  fmt_in = FMT_U32LE;
               end else if (n3 && h[0] == BOM_EF && h[1] == BOM_BB
                      && h[2] == BOM_BF) begin
                  fmt_in = FMT_PASS;
                  if (n4) begin
                     grp.bytes[0] = h[3];
                     grp.count    = 3'd1;
                  end
               end else if (n2 && h[0] == BOM_FE && h[1] == BOM_FF) begin
                  fmt_in = FMT_U16BE;
                  if (n4) begin
                     enc_unit = {16'd0, h[2], h[3]};
                  end
               end else if (n2 && h[0] == BOM_FF && h[1] == BOM_FE) begin
                  fmt_in = FMT_U16LE;
                  if (n4) begin
                     enc_unit = {16'd0, h[3], h[2]};
                  end
               end else begin
                  fmt_in = FMT_PASS;
                  for (int i = 0; i < 4; i++) begin
                     grp.bytes[i] = h[i];
                  end
                  grp.count = 3'(cnt_ff) + 3'd1;
               end
               // A full UTF-16 unit follows the two-byte BOM in the held bytes.
               if (n4 && (fmt_in == FMT_U16BE || fmt_in == FMT_U16LE)) begin
                  uval_in = enc_unit;
                  if (enc_unit == 32'd0) begin
                     stop_in = 1'b1;
                  end else begin
                     use_enc = 1'b1;
                  end
               end
            end
         end
      endcase

      if (use_enc) begin
         grp = enc_grp;
      end

      // The end of a buffer brings everything back to the BOM check.
      if (item_ff.in_last) begin
         fmt_in  = FMT_CHECK;
         cnt_in  = 2'd0;
         uval_in = '0;
         ubc_in  = 2'd0;
         stop_in = 1'b0;
      end
   end

   assign grp_data  = grp;
   assign grp_valid = full_ff && (grp.count != 3'd0);
   assign adv       = full_ff && ((grp.count == 3'd0) || grp_ready);
   assign req_stall = full_ff && !adv;
   assign accept    = req_valid && !req_stall;
   assign full_in   = accept || (full_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         fmt_ff  <= FMT_CHECK;
         cnt_ff  <= 2'd0;
         uval_ff <= '0;
         ubc_ff  <= 2'd0;
         stop_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
         if (adv) begin
            fmt_ff  <= fmt_in;
            cnt_ff  <= cnt_in;
            uval_ff <= uval_in;
            ubc_ff  <= ubc_in;
            stop_ff <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (adv) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- rtl/bsu_serial.sv -----
`timescale 1ns / 1ps
module bsu_serial
   import bsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    grp_valid,
   output logic    grp_ready,
   input  grp_type grp_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [5:0][7:0] data_ff;
   logic [2:0]      left_ff;
   logic            take;
   logic            load;

   assign rsp_valid             = (left_ff != 3'd0);
   assign rsp_data.out_byte     = data_ff[0];
   assign rsp_data.out_run_last = (left_ff == 3'd1);

   assign take      = rsp_valid && !rsp_stall;
   // A new group may enter in the cycle the last word of the current one leaves.
   assign grp_ready = (left_ff == 3'd0) || (take && left_ff == 3'd1);
   assign load      = grp_valid && grp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
      end else if (load) begin
         left_ff <= grp_data.count;
      end else if (take) begin
         left_ff <= 3'(left_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= grp_data.bytes;
      end else if (take) begin
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            data_ff[i] <= data_ff[i + 1];
         end
         data_ff[MAX_BYTES - 1] <= '0;
      end
   end

endmodule
